FILE: rtl/core/dnv_pkg.sv
// Shared types, constants and the character class helper for the DNS name validator.
// Depends on nothing; every module of the block imports it.
package dnv_pkg;

    // Limits of a name and of one label.
    localparam int MAX_NAME_LENGTH = 255;
    localparam int MAX_LABEL_INDEX = 62;

    // Counter widths: the total count saturates one above the name limit.
    localparam int NAME_CNT_W  = $clog2(MAX_NAME_LENGTH + 2);
    localparam int LABEL_CNT_W = 7;
    localparam logic [LABEL_CNT_W-1:0] LABEL_SAT = {LABEL_CNT_W{1'b1}};

    // Depth of the queue between the front and back halves.
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    // Field widths.
    localparam int CU_W  = 16;
    localparam int FMT_W = 3;

    // Characters that the rules look at.
    localparam logic [CU_W-1:0] CH_SPACE  = 16'h0020;
    localparam logic [CU_W-1:0] CH_STAR   = 16'h002A;
    localparam logic [CU_W-1:0] CH_DOT    = 16'h002E;
    localparam logic [CU_W-1:0] CH_DIGIT0 = 16'h0030;
    localparam logic [CU_W-1:0] CH_DIGIT9 = 16'h0039;
    localparam logic [CU_W-1:0] CH_USCORE = 16'h005F;
    localparam logic [CU_W-1:0] CH_ASCII  = 16'h007F;

    // Name formats.
    localparam logic [FMT_W-1:0] FMT_DOMAIN       = 3'd0;
    localparam logic [FMT_W-1:0] FMT_DOMAIN_LABEL = 3'd1;
    localparam logic [FMT_W-1:0] FMT_HOST         = 3'd2;
    localparam logic [FMT_W-1:0] FMT_HOST_LABEL   = 3'd3;
    localparam logic [FMT_W-1:0] FMT_WILDCARD     = 3'd4;
    localparam logic [FMT_W-1:0] FMT_SRV          = 3'd5;

    // Verdict codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_NAME = 2'd1,
        ST_NON_RFC  = 2'd2,
        ST_BAD_CHAR = 2'd3
    } t_status;

    // Class flags collected over one name.
    typedef struct packed {
        logic long_label;
        logic underscore;
        logic asterisk;
        logic invalid;
        logic space;
        logic dot_dot;
        logic dot;
        logic non_numeric;
        logic numeric;
        logic extended;
    } t_flags;

    // Summary of one finished name, handed from the front to the back.
    typedef struct packed {
        t_flags                flags;
        logic [NAME_CNT_W-1:0] total;
        logic                  first_dot;
        logic                  first_star;
        logic                  first_uscore;
        logic                  second_dot;
        logic [FMT_W-1:0]      fmt;
    } t_name_sum;

    // Fixed set of punctuation that is never allowed in a name.
    function automatic logic is_bad_char(input logic [CU_W-1:0] c);
        return c inside {[16'h0021:16'h0029], 16'h002B, 16'h002C, 16'h002F,
                         [16'h003A:16'h0040], [16'h005B:16'h005E], 16'h0060,
                         [16'h007B:16'h007E]};
    endfunction

endpackage

FILE: rtl/core/dnv_front.sv
// Front half: accepts code units, classifies them and keeps the per-name state.
// Depends on dnv_pkg; pushes one name summary per terminator into the queue.
module dnv_front import dnv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CU_W-1:0]   i_code_unit,
    input  logic [FMT_W-1:0]  i_name_format,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_name_sum         o_q_data
);

    t_flags                 r_flags, n_flags;
    logic [NAME_CNT_W-1:0]  r_total, n_total;
    logic [LABEL_CNT_W-1:0] r_label, n_label;
    logic                   r_first_dot, n_first_dot;
    logic                   r_first_star, n_first_star;
    logic                   r_first_uscore, n_first_uscore;
    logic                   r_second_dot, n_second_dot;
    logic                   r_prev_dot, n_prev_dot;

    logic                   w_term;
    logic                   w_accept;
    logic                   w_is_dot;
    logic [LABEL_CNT_W-1:0] w_idx;

    // A terminator waits only when the queue has no room; other units always pass.
    assign w_term     = (i_code_unit == '0);
    assign o_in_stall = w_term && i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_q_push   = w_accept && w_term;

    // The summary reflects the state before the terminator clears it.
    assign o_q_data = '{flags:        r_flags,
                        total:        r_total,
                        first_dot:    r_first_dot,
                        first_star:   r_first_star,
                        first_uscore: r_first_uscore,
                        second_dot:   r_second_dot,
                        fmt:          i_name_format};

    assign w_is_dot = (i_code_unit == CH_DOT);
    assign w_idx    = w_is_dot ? '0 : r_label;

    // Classification of one code unit and update of the counters.
    always_comb begin
        n_flags        = r_flags;
        n_total        = r_total;
        n_label        = r_label;
        n_first_dot    = r_first_dot;
        n_first_star   = r_first_star;
        n_first_uscore = r_first_uscore;
        n_second_dot   = r_second_dot;
        n_prev_dot     = r_prev_dot;
        if (w_term) begin
            n_flags        = '0;
            n_total        = '0;
            n_label        = '0;
            n_first_dot    = 1'b0;
            n_first_star   = 1'b0;
            n_first_uscore = 1'b0;
            n_second_dot   = 1'b0;
            n_prev_dot     = 1'b0;
        end else begin
            if (w_is_dot) begin
                n_flags.dot = 1'b1;
                if (r_prev_dot) begin
                    n_flags.dot_dot = 1'b1;
                end
            end else if (i_code_unit < CH_DIGIT0 || i_code_unit > CH_DIGIT9) begin
                n_flags.non_numeric = 1'b1;
            end else begin
                n_flags.numeric = 1'b1;
            end
            if (w_idx > LABEL_CNT_W'(MAX_LABEL_INDEX)) begin
                n_flags.long_label = 1'b1;
            end
            n_label = (w_idx < LABEL_SAT) ? w_idx + 1'b1 : LABEL_SAT;

            if (is_bad_char(i_code_unit)) begin
                n_flags.invalid = 1'b1;
            end else if (i_code_unit > CH_ASCII) begin
                n_flags.extended = 1'b1;
            end else if (i_code_unit == CH_SPACE) begin
                n_flags.space = 1'b1;
            end else if (i_code_unit == CH_USCORE) begin
                n_flags.underscore = 1'b1;
            end else if (i_code_unit == CH_STAR) begin
                n_flags.asterisk = 1'b1;
            end

            if (r_total == '0) begin
                n_first_dot    = w_is_dot;
                n_first_star   = (i_code_unit == CH_STAR);
                n_first_uscore = (i_code_unit == CH_USCORE);
            end else if (r_total == NAME_CNT_W'(1)) begin
                n_second_dot = w_is_dot;
            end
            if (r_total < NAME_CNT_W'(MAX_NAME_LENGTH + 1)) begin
                n_total = r_total + 1'b1;
            end
            n_prev_dot = w_is_dot;
        end
    end

    // Per-name state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags        <= '0;
            r_total        <= '0;
            r_label        <= '0;
            r_first_dot    <= 1'b0;
            r_first_star   <= 1'b0;
            r_first_uscore <= 1'b0;
            r_second_dot   <= 1'b0;
            r_prev_dot     <= 1'b0;
        end else if (w_accept) begin
            r_flags        <= n_flags;
            r_total        <= n_total;
            r_label        <= n_label;
            r_first_dot    <= n_first_dot;
            r_first_star   <= n_first_star;
            r_first_uscore <= n_first_uscore;
            r_second_dot   <= n_second_dot;
            r_prev_dot     <= n_prev_dot;
        end
    end

`ifndef SYNTHESIS
    // Only a terminator is ever held back.
    a_stall_on_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (i_code_unit == '0))
        else $error("front stalls a non-terminating code unit");

    // After a terminator is taken the next name starts from a clean state.
    a_clear_after_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |=> (r_total == '0) && (r_flags == '0) && (r_label == '0))
        else $error("name state not cleared after terminator");
`endif

endmodule

FILE: rtl/core/dnv_queue.sv
// Short register queue of name summaries between the front and back halves.
// Depends on dnv_pkg for the summary type and the depth.
module dnv_queue import dnv_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_name_sum i_data,
    input  logic      i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_name_sum o_data
);

    t_name_sum          r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, n_wptr;
    logic [Q_PTR_W-1:0] r_rptr, n_rptr;
    logic [Q_CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    // Pointer wrap and occupancy.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    // The front never writes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue push while full");

    // The back never reads an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");

    // Occupancy stays within the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

FILE: rtl/core/dnv_back.sv
// Back half: turns a name summary into a verdict and holds it in the output register.
// Depends on dnv_pkg; reads summaries from dnv_queue.
module dnv_back import dnv_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_name_sum i_q_data,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output logic [1:0] o_status
);

    logic    r_out_valid;
    t_status r_status, n_status;
    logic    w_only_digits;
    logic    w_shared_bad;
    t_status w_char_rules;
    t_flags  w_f;

    // A new verdict enters whenever the output register is free or being taken.
    assign o_q_pop     = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

    assign w_f           = i_q_data.flags;
    assign w_only_digits = !w_f.non_numeric && w_f.numeric;

    // Length and dot checks shared by every format.
    assign w_shared_bad = (i_q_data.total == '0) ||
                          (i_q_data.total > NAME_CNT_W'(MAX_NAME_LENGTH)) ||
                          w_f.long_label || w_f.dot_dot ||
                          (i_q_data.first_dot && i_q_data.total > NAME_CNT_W'(1));

    // Character rules of the domain and host formats.
    always_comb begin
        if (w_f.extended || w_f.underscore) begin
            w_char_rules = ST_NON_RFC;
        end else if (w_f.space || w_f.invalid || w_f.asterisk) begin
            w_char_rules = ST_BAD_CHAR;
        end else begin
            w_char_rules = ST_OK;
        end
    end

    // Format-specific rules.
    always_comb begin
        n_status = ST_OK;
        if (w_shared_bad) begin
            n_status = ST_BAD_NAME;
        end else begin
            case (i_q_data.fmt)
                FMT_DOMAIN, FMT_HOST: begin
                    n_status = w_char_rules;
                end
                FMT_DOMAIN_LABEL, FMT_HOST_LABEL: begin
                    n_status = w_f.dot ? ST_BAD_NAME : w_char_rules;
                end
                FMT_WILDCARD: begin
                    if (w_only_digits || !i_q_data.first_star) begin
                        n_status = ST_BAD_NAME;
                    end else if (i_q_data.total > NAME_CNT_W'(1) && !i_q_data.second_dot) begin
                        n_status = ST_BAD_CHAR;
                    end else if (w_f.extended || w_f.space || w_f.invalid) begin
                        n_status = ST_BAD_NAME;
                    end
                end
                FMT_SRV: begin
                    if (w_only_digits || !i_q_data.first_uscore) begin
                        n_status = ST_BAD_NAME;
                    end else if (w_f.underscore && i_q_data.total == NAME_CNT_W'(1)) begin
                        n_status = ST_NON_RFC;
                    end else if (w_f.extended || w_f.space || w_f.invalid) begin
                        n_status = ST_BAD_NAME;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_status <= n_status;
        end
    end

`ifndef SYNTHESIS
    // A waiting verdict is never overwritten by the next one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_q_pop)
        else $error("verdict overwritten while stalled");

    // An empty name can only end as an invalid name.
    a_empty_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_data.total == '0) |=> (r_status == ST_BAD_NAME))
        else $error("empty name not rejected");
`endif

endmodule

FILE: rtl/core/dns_name_validator_top.sv
// Channel     | Direction | Handshake                  | Payload
// ------------+-----------+----------------------------+-----------------------------
// request in  | input     | i_in_valid / o_in_stall    | i_code_unit, i_name_format
// verdict out | output    | o_out_valid / i_out_stall  | o_status
//
// One code unit is taken per cycle, unless a terminator is held back by a full summary queue.
// After its terminator is taken, a verdict passes through the queue, then the output register.
// The front stalls a terminator only when the two-entry summary queue is full.
// Ordinary code units are never stalled; only the output stall backs up into the queue.
// Reset is synchronous and active low; it clears all name state and the queue.
//
// Top level of the DNS name validator; depends on dnv_pkg, dnv_front, dnv_queue, dnv_back.
module dns_name_validator_top import dnv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [CU_W-1:0]  i_code_unit,
    input  logic [FMT_W-1:0] i_name_format,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [1:0]       o_status
);

    logic      w_push;
    logic      w_pop;
    logic      w_full;
    logic      w_q_valid;
    t_name_sum w_push_data;
    t_name_sum w_q_data;

    // Classification and per-name counters.
    dnv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_code_unit   (i_code_unit),
        .i_name_format (i_name_format),
        .i_q_full      (w_full),
        .o_q_push      (w_push),
        .o_q_data      (w_push_data)
    );

    // Summary queue.
    dnv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    // Verdict and output register.
    dnv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_data),
        .o_q_pop     (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status)
    );

endmodule
